/* design/bcll_pkg.sv */
package bcll_pkg;

   // Sizing of the broker table and the bin table.
   localparam int MAX_BROKERS  = 8;
   localparam int NUM_BINS     = 16;
   localparam int BIN_COUNT    = NUM_BINS + 2;
   localparam int BROKER_W     = $clog2(MAX_BROKERS);
   localparam int BROKER_CNT_W = $clog2(MAX_BROKERS + 1);
   localparam int BIN_W        = $clog2(BIN_COUNT);

   // Field and state widths.
   localparam int NORM_W       = 32;
   localparam int TIME_W       = 32;
   localparam int PRED_W       = 32;
   localparam int LOAD_W       = 48;
   localparam int SUM_W        = 48;
   localparam int COUNT_W      = 16;
   localparam int NB_CFG_W     = 4;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 32;

   // Shared divider: a 48-bit dividend register and a 32-bit divisor.
   localparam int DIV_Q_W      = 48;
   localparam int DIV_D_W      = 32;
   localparam int DIV_CNT_W    = 6;
   localparam int BIN_STEPS    = NORM_W;
   localparam int MEAN_STEPS   = SUM_W;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_NUMBER_BROKERS      = 2'd0,
      CSR_MAX_SAMPLES_PER_BIN = 2'd1,
      CSR_MIN_NORM            = 2'd2,
      CSR_BIN_WIDTH           = 2'd3
   } csr_index_type;

   // Operation codes.
   typedef enum logic [0:0] {
      OP_SCHEDULE = 1'b0,
      OP_UPDATE   = 1'b1
   } op_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BIN_DIV,
      ST_BIN_FIX,
      ST_DISPATCH,
      ST_SCAN,
      ST_LOAD_ADD,
      ST_MEAN_DIV,
      ST_PRED_WRITE
   } state_type;

   typedef struct packed {
      op_type            opcode;
      logic [NORM_W-1:0] norm_value;
      logic [TIME_W-1:0] measured_time;
   } req_type;

   typedef struct packed {
      logic [2:0] broker_id;
      logic       used_prediction;
      logic       sample_stored;
      logic [4:0] bin_index;
   } rsp_type;

endpackage

/* design/binned_cost_least_loaded_scheduler.sv */
// Binned-cost least-loaded scheduler. A transaction is taken when start is high and busy is
// low; exactly one result follows, shown for one cycle with rsp_valid, and the receiver cannot
// stall it. Everything runs on one shared restoring divider that retires one quotient bit per
// cycle. A schedule transaction bins the norm with the divider, fixes the bin and reads its
// prediction, then scans broker loads and adds the cost to the least-loaded one; round robin is
// used when the bin has no prediction yet. A norm below min_norm skips the binning. An update
// transaction that stores its sample adds a mean division and a step to write the prediction.
// busy drops in the cycle the result appears, so the next transaction can start then.
// Configuration writes are always ready and take effect at once.
module binned_cost_least_loaded_scheduler (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  bcll_pkg::req_type                   req,
   output logic                                rsp_valid,
   output bcll_pkg::rsp_type                   rsp,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [bcll_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [bcll_pkg::CSR_DATA_W-1:0]     csr_data
);
   import bcll_pkg::*;

   state_type                state_ff, state_in;

   // Configuration registers.
   logic [NB_CFG_W-1:0]      nb_cfg_ff;
   logic [COUNT_W-1:0]       max_samples_ff;
   logic [NORM_W-1:0]        min_norm_ff;
   logic [NORM_W-1:0]        bin_width_ff;

   // Model state.
   logic [LOAD_W-1:0]        load_ff [MAX_BROKERS];
   logic [LOAD_W-1:0]        load_in [MAX_BROKERS];
   logic [COUNT_W-1:0]       cnt_ff  [BIN_COUNT];
   logic [COUNT_W-1:0]       cnt_in  [BIN_COUNT];
   logic [SUM_W-1:0]         sum_ff  [BIN_COUNT];
   logic [SUM_W-1:0]         sum_in  [BIN_COUNT];
   logic [PRED_W-1:0]        pred_ff [BIN_COUNT];
   logic [PRED_W-1:0]        pred_in [BIN_COUNT];
   logic [BROKER_W-1:0]      rr_ff, rr_in;

   // Per-transaction working registers.
   req_type                  req_ff, req_in;
   logic [BIN_W-1:0]         bin_ff, bin_in;
   logic [PRED_W-1:0]        cost_ff, cost_in;
   logic [BROKER_W-1:0]      best_ff, best_in;
   logic [LOAD_W-1:0]        best_load_ff, best_load_in;
   logic [BROKER_W-1:0]      scan_ff, scan_in;

   // Shared divider.
   logic [DIV_Q_W-1:0]       div_q_ff, div_q_in;
   logic [DIV_D_W-1:0]       div_r_ff, div_r_in;
   logic [DIV_D_W-1:0]       div_d_ff, div_d_in;
   logic [DIV_CNT_W-1:0]     div_cnt_ff, div_cnt_in;

   // Result register.
   rsp_type                  rsp_ff, rsp_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   // Shared combinational terms.
   logic                     accept;
   logic                     below_min;
   logic [NORM_W-1:0]        norm_off;
   logic [BROKER_CNT_W-1:0]  nb_eff;
   logic [PRED_W-1:0]        cur_cost;
   logic [COUNT_W-1:0]       cur_cnt;
   logic                     can_store;
   logic                     scan_last;
   logic [DIV_D_W:0]         div_shift;
   logic [DIV_D_W:0]         div_diff;
   logic                     div_ge;
   logic [BROKER_CNT_W-1:0]  rr_plus;
   logic [LOAD_W:0]          load_sum;
   logic [SUM_W:0]           time_sum;
   logic [SUM_W-1:0]         new_sum;
   logic [COUNT_W-1:0]       new_cnt;
   logic [DIV_D_W-1:0]       bin_quot;

   assign accept    = start && (state_ff == ST_IDLE);
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   assign below_min = req.norm_value < min_norm_ff;
   assign norm_off  = req.norm_value - min_norm_ff;

   // Brokers in use: zero acts as one, anything above the table size as the table size.
   always_comb begin
      if (nb_cfg_ff == '0) begin
         nb_eff = BROKER_CNT_W'(1);
      end else if (BROKER_CNT_W'(nb_cfg_ff) > BROKER_CNT_W'(MAX_BROKERS)) begin
         nb_eff = BROKER_CNT_W'(MAX_BROKERS);
      end else begin
         nb_eff = BROKER_CNT_W'(nb_cfg_ff);
      end
   end

   assign cur_cost  = pred_ff[bin_ff];
   assign cur_cnt   = cnt_ff[bin_ff];
   assign can_store = cur_cnt < max_samples_ff;
   assign scan_last = ({1'b0, scan_ff} == (nb_eff - BROKER_CNT_W'(1)));
   assign rr_plus   = {1'b0, rr_ff} + BROKER_CNT_W'(1);
   assign bin_quot  = div_q_ff[DIV_D_W-1:0];

   // One restoring division step: shift in the next dividend bit, subtract when it fits.
   assign div_shift = {div_r_ff, div_q_ff[DIV_Q_W-1]};
   assign div_diff  = div_shift - {1'b0, div_d_ff};
   assign div_ge    = div_shift >= {1'b0, div_d_ff};

   // Saturating adds for the broker load and the bin time sum.
   assign load_sum  = {1'b0, best_load_ff} + {{(LOAD_W - PRED_W + 1){1'b0}}, cost_ff};
   assign time_sum  = {1'b0, sum_ff[bin_ff]} + {{(SUM_W - TIME_W + 1){1'b0}},
                                                  req_ff.measured_time};
   assign new_sum   = time_sum[SUM_W] ? {SUM_W{1'b1}} : time_sum[SUM_W-1:0];
   assign new_cnt   = cur_cnt + COUNT_W'(1);

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = below_min ? ST_DISPATCH : ST_BIN_DIV;
            end
         end
         ST_BIN_DIV: begin
            if (div_cnt_ff == DIV_CNT_W'(1)) begin
               state_in = ST_BIN_FIX;
            end
         end
         ST_BIN_FIX: begin
            state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            if (req_ff.opcode == OP_SCHEDULE) begin
               if (cur_cost == '0) begin
                  state_in = ST_IDLE;
               end else if (nb_eff == BROKER_CNT_W'(1)) begin
                  state_in = ST_LOAD_ADD;
               end else begin
                  state_in = ST_SCAN;
               end
            end else begin
               state_in = can_store ? ST_MEAN_DIV : ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (scan_last) begin
               state_in = ST_LOAD_ADD;
            end
         end
         ST_LOAD_ADD: begin
            state_in = ST_IDLE;
         end
         ST_MEAN_DIV: begin
            if (div_cnt_ff == DIV_CNT_W'(1)) begin
               state_in = ST_PRED_WRITE;
            end
         end
         ST_PRED_WRITE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output and datapath logic.
   always_comb begin
      req_in       = req_ff;
      bin_in       = bin_ff;
      cost_in      = cost_ff;
      best_in      = best_ff;
      best_load_in = best_load_ff;
      scan_in      = scan_ff;
      rr_in        = rr_ff;
      div_q_in     = div_q_ff;
      div_r_in     = div_r_ff;
      div_d_in     = div_d_ff;
      div_cnt_in   = div_cnt_ff;
      load_in      = load_ff;
      cnt_in       = cnt_ff;
      sum_in       = sum_ff;
      pred_in      = pred_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            // Latch the transaction and start binning unless the norm is below range.
            if (accept) begin
               req_in     = req;
               bin_in     = '0;
               div_q_in   = {norm_off, {(DIV_Q_W - NORM_W){1'b0}}};
               div_r_in   = '0;
               div_d_in   = bin_width_ff;
               div_cnt_in = DIV_CNT_W'(BIN_STEPS);
            end
         end
         ST_BIN_DIV, ST_MEAN_DIV: begin
            div_q_in   = {div_q_ff[DIV_Q_W-2:0], div_ge};
            div_r_in   = div_ge ? div_diff[DIV_D_W-1:0] : div_shift[DIV_D_W-1:0];
            div_cnt_in = div_cnt_ff - DIV_CNT_W'(1);
         end
         ST_BIN_FIX: begin
            // Quotients past the last regular bin land in the top bin.
            if (bin_quot >= DIV_D_W'(NUM_BINS)) begin
               bin_in = BIN_W'(BIN_COUNT - 1);
            end else begin
               bin_in = bin_quot[BIN_W-1:0] + BIN_W'(1);
            end
         end
         ST_DISPATCH: begin
            rsp_in.broker_id       = '0;
            rsp_in.used_prediction = 1'b0;
            rsp_in.sample_stored   = 1'b0;
            rsp_in.bin_index       = 5'(bin_ff);
            if (req_ff.opcode == OP_SCHEDULE) begin
               if (cur_cost == '0) begin
                  // No prediction yet: hand out the round-robin broker.
                  rsp_in.broker_id = 3'(rr_ff);
                  rsp_valid_in     = 1'b1;
                  rr_in = (rr_plus >= nb_eff) ? '0 : rr_plus[BROKER_W-1:0];
               end else begin
                  cost_in      = cur_cost;
                  best_in      = '0;
                  best_load_in = load_ff[0];
                  scan_in      = BROKER_W'(1);
               end
            end else begin
               if (can_store) begin
                  cnt_in[bin_ff] = new_cnt;
                  sum_in[bin_ff] = new_sum;
                  div_q_in       = new_sum;
                  div_r_in       = '0;
                  div_d_in       = {{(DIV_D_W - COUNT_W){1'b0}}, new_cnt};
                  div_cnt_in     = DIV_CNT_W'(MEAN_STEPS);
               end else begin
                  rsp_valid_in = 1'b1;
               end
            end
         end
         ST_SCAN: begin
            // Strictly less keeps the lowest-numbered broker on ties.
            if (load_ff[scan_ff] < best_load_ff) begin
               best_in      = scan_ff;
               best_load_in = load_ff[scan_ff];
            end
            scan_in = scan_ff + BROKER_W'(1);
         end
         ST_LOAD_ADD: begin
            load_in[best_ff]       = load_sum[LOAD_W] ? {LOAD_W{1'b1}} : load_sum[LOAD_W-1:0];
            rsp_in.broker_id       = 3'(best_ff);
            rsp_in.used_prediction = 1'b1;
            rsp_valid_in           = 1'b1;
         end
         ST_PRED_WRITE: begin
            // Means that do not fit in 32 bits saturate.
            pred_in[bin_ff] = (|div_q_ff[DIV_Q_W-1:PRED_W]) ? {PRED_W{1'b1}}
                                                            : div_q_ff[PRED_W-1:0];
            rsp_in.sample_stored = 1'b1;
            rsp_valid_in         = 1'b1;
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   // Control state, configuration and model state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         rr_ff          <= '0;
         nb_cfg_ff      <= NB_CFG_W'(8);
         max_samples_ff <= COUNT_W'(64);
         min_norm_ff    <= '0;
         bin_width_ff   <= NORM_W'(65536);
         for (int i = 0; i < MAX_BROKERS; i++) begin
            load_ff[i] <= '0;
         end
         for (int i = 0; i < BIN_COUNT; i++) begin
            cnt_ff[i]  <= '0;
            sum_ff[i]  <= '0;
            pred_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rr_ff        <= rr_in;
         load_ff      <= load_in;
         cnt_ff       <= cnt_in;
         sum_ff       <= sum_in;
         pred_ff      <= pred_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_NUMBER_BROKERS:      nb_cfg_ff      <= csr_data[NB_CFG_W-1:0];
               CSR_MAX_SAMPLES_PER_BIN: max_samples_ff <= csr_data[COUNT_W-1:0];
               CSR_MIN_NORM:            min_norm_ff    <= csr_data[NORM_W-1:0];
               CSR_BIN_WIDTH:           bin_width_ff   <= csr_data[NORM_W-1:0];
               default:                 nb_cfg_ff      <= nb_cfg_ff;
            endcase
         end
      end
   end

   // Working and result payload registers.
   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      bin_ff       <= bin_in;
      cost_ff      <= cost_in;
      best_ff      <= best_in;
      best_load_ff <= best_load_in;
      scan_ff      <= scan_in;
      div_q_ff     <= div_q_in;
      div_r_ff     <= div_r_in;
      div_d_ff     <= div_d_in;
      div_cnt_ff   <= div_cnt_in;
      rsp_ff       <= rsp_in;
   end

   // An accepted transaction keeps the block busy until its result.
   assert property (@(posedge clock) disable iff (reset) (start && !busy) |=> busy)
      else $error("accepted transaction did not make the block busy");

   // A result only ends work in progress, and the block is free while it shows.
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> $past(busy) && !busy)
      else $error("result without a transaction in progress");

   // Each transaction gives a single one-cycle result.
   assert property (@(posedge clock) disable iff (reset) rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   // A least-load choice never reports a stored sample.
   assert property (@(posedge clock) disable iff (reset)
                    (rsp_valid && rsp.used_prediction) |-> !rsp.sample_stored)
      else $error("schedule result flagged a stored sample");

endmodule
